// ----- rtl/core/b2nv12_pkg.sv -----
// ----------------------------------------------------------------------------
// b2nv12_pkg
// Shared types, constants and color math for the BGRA to NV12 converter.
// ----------------------------------------------------------------------------
package b2nv12_pkg;

  localparam int unsigned MaxWidth  = 4096;
  localparam int unsigned MaxHeight = 4096;

  localparam int DimW        = 13;  // dimension registers
  localparam int CntW        = 12;  // raster counters
  localparam int PitchW      = 16;
  localparam int DivW        = DimW + CntW;  // counter times source size
  localparam int DivCntW     = $clog2(DivW);
  localparam int LumaOffW    = 28;
  localparam int ChromaOffW  = 29;
  localparam int FetchW      = 26;
  localparam int FetchIdxW   = FetchW - 2;   // pixel index, four bytes per pixel
  localparam int CfgIdxW     = 3;

  // Register indexes of the configuration port.
  localparam logic [CfgIdxW-1:0] CfgSrcWidth  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgSrcHeight = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgDstWidth  = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgDstHeight = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgDstPitch  = 3'd4;

  typedef struct packed {
    logic       mode;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } in_t;

  typedef struct packed {
    logic                  pixel_valid;
    logic [7:0]            luma;
    logic [LumaOffW-1:0]   luma_offset;
    logic                  chroma_valid;
    logic [7:0]            chroma_blue;
    logic [7:0]            chroma_red;
    logic [ChromaOffW-1:0] chroma_offset;
    logic [FetchW-1:0]     next_fetch_offset;
    logic                  frame_last;
  } out_t;

  typedef struct packed {
    logic [DimW-1:0]   src_width;
    logic [DimW-1:0]   src_height;
    logic [DimW-1:0]   dst_width;
    logic [DimW-1:0]   dst_height;
    logic [PitchW-1:0] dst_pitch;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUM,
    ST_DIV,
    ST_ROW,
    ST_FETCH,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic capture;
    logic mul;
    logic sum;
    logic div_start;
    logic row;
    logic fetch;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_free;
  } sts_t;

  // A size of zero acts as one, a size above the maximum acts as the maximum.
  function automatic logic [DimW-1:0] eff_dim(input logic [DimW-1:0] v,
                                               input logic [DimW-1:0] max_v);
    logic [DimW-1:0] r;
    if (v == '0) begin
      r = DimW'(1);
    end else if (v > max_v) begin
      r = max_v;
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [7:0] calc_luma(input logic [7:0] r, input logic [7:0] g,
                                           input logic [7:0] b);
    logic [15:0] s;
    logic [8:0]  y;
    s = 16'd66 * 16'(r) + 16'd129 * 16'(g) + 16'd25 * 16'(b) + 16'd128;
    y = 9'(s[15:8]) + 9'd16;
    return (y > 9'd255) ? 8'hFF : y[7:0];
  endfunction

  // The sum already carries the +128 offset scaled by 256. A negative sum
  // behaves as a huge unsigned value and clamps high.
  function automatic logic [7:0] clamp_chroma(input logic signed [17:0] s);
    logic [7:0] c;
    if (s[17:16] != 2'b00) begin
      c = 8'hFF;
    end else begin
      c = s[15:8];
    end
    return c;
  endfunction

  function automatic logic [7:0] calc_cb(input logic [7:0] r, input logic [7:0] g,
                                         input logic [7:0] b);
    logic signed [17:0] s;
    s = -18'sd38 * $signed({10'b0, r}) - 18'sd74 * $signed({10'b0, g})
        + 18'sd112 * $signed({10'b0, b}) + 18'sd32896;
    return clamp_chroma(s);
  endfunction

  function automatic logic [7:0] calc_cr(input logic [7:0] r, input logic [7:0] g,
                                         input logic [7:0] b);
    logic signed [17:0] s;
    s = 18'sd112 * $signed({10'b0, r}) - 18'sd94 * $signed({10'b0, g})
        - 18'sd18 * $signed({10'b0, b}) + 18'sd32896;
    return clamp_chroma(s);
  endfunction

endpackage

// ----- rtl/core/b2nv12_div.sv -----
// ----------------------------------------------------------------------------
// b2nv12_div
// Restoring divider, one quotient bit per cycle, for source coordinate lookup.
// ----------------------------------------------------------------------------
module b2nv12_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [b2nv12_pkg::DivW-1:0]    dividend_i,
  input  logic [b2nv12_pkg::DimW-1:0]    divisor_i,
  output logic                           done_o,
  output logic [b2nv12_pkg::DivW-1:0]    quotient_o
);
  import b2nv12_pkg::*;

  logic                busy_q;
  logic [DivCntW-1:0]  cnt_q;
  logic [DimW-1:0]     rem_q, rem_d;
  logic [DivW-1:0]     quo_q;
  logic [DimW:0]       trial, diff;
  logic                fits;

  // The dividend shifts out of the top of quo_q while quotient bits enter below.
  always_comb begin
    trial = {rem_q, quo_q[DivW-1]};
    diff  = trial - {1'b0, divisor_i};
    fits  = (trial >= {1'b0, divisor_i});
    rem_d = fits ? diff[DimW-1:0] : trial[DimW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
    end else if (busy_q && cnt_q == DivCntW'(DivW - 1)) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      cnt_q <= '0;
      rem_q <= '0;
      quo_q <= dividend_i;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      rem_q <= rem_d;
      quo_q <= {quo_q[DivW-2:0], fits};
    end
  end

  assign done_o     = !busy_q;
  assign quotient_o = quo_q;

endmodule

// ----- rtl/core/b2nv12_ctrl.sv -----
// ----------------------------------------------------------------------------
// b2nv12_ctrl
// Sequencer that steps one item through the converter datapath.
// ----------------------------------------------------------------------------
module b2nv12_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  b2nv12_pkg::sts_t    sts_i,
  output b2nv12_pkg::cmd_t    cmd_o
);
  import b2nv12_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_SUM;
      end
      ST_SUM: begin
        cmd_o.sum       = 1'b1;
        cmd_o.div_start = 1'b1;
        state_d         = ST_DIV;
      end
      ST_DIV: begin
        if (sts_i.div_done) begin
          state_d = ST_ROW;
        end
      end
      ST_ROW: begin
        cmd_o.row = 1'b1;
        state_d   = ST_FETCH;
      end
      ST_FETCH: begin
        cmd_o.fetch = 1'b1;
        state_d     = ST_OUT;
      end
      ST_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.load = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/core/b2nv12_dp.sv -----
// ----------------------------------------------------------------------------
// b2nv12_dp
// Datapath: raster counters, color conversion, offsets and source lookup.
// ----------------------------------------------------------------------------
module b2nv12_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  b2nv12_pkg::cfg_t    cfg_i,
  input  b2nv12_pkg::in_t     in_data_i,
  input  b2nv12_pkg::cmd_t    cmd_i,
  output b2nv12_pkg::sts_t    sts_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output b2nv12_pkg::out_t    out_data_o
);
  import b2nv12_pkg::*;

  logic [DimW-1:0] sw_eff, sh_eff, dw_eff, dh_eff, sw_m1, sh_m1;
  logic [DimW-1:0] col_inc, row_inc;
  logic            last_col, last_row;

  logic [CntW-1:0] col_q, row_q;
  logic            mode_q, last_q;
  logic [7:0]      red_q, green_q, blue_q;
  logic [CntW-1:0] dx_q, dy_q;

  logic [7:0]            luma_q, cb_q, cr_q;
  logic [LumaOffW-1:0]   prod_luma, prod_luma_q;
  logic [LumaOffW-2:0]   prod_half, prod_half_q;
  logic [ChromaOffW-1:0] prod_base, prod_base_q;
  logic [DivW-1:0]       prod_x, prod_x_q, prod_y, prod_y_q;

  logic [LumaOffW-1:0]   luma_off_q;
  logic [ChromaOffW-1:0] chroma_off_q;

  logic                  x_done, y_done;
  logic [DivW-1:0]       quo_x, quo_y, sx_sat, sy_sat;
  logic [CntW-1:0]       sx_q, rowsel_q;
  logic [DivW-1:0]       prod_fetch;
  logic [FetchIdxW-1:0]  fetch_q;

  logic                  out_valid_q;
  out_t                  out_q, out_d;
  logic                  chroma_pos;

  always_comb begin
    sw_eff   = eff_dim(cfg_i.src_width,  DimW'(MaxWidth));
    sh_eff   = eff_dim(cfg_i.src_height, DimW'(MaxHeight));
    dw_eff   = eff_dim(cfg_i.dst_width,  DimW'(MaxWidth));
    dh_eff   = eff_dim(cfg_i.dst_height, DimW'(MaxHeight));
    sw_m1    = sw_eff - 1'b1;
    sh_m1    = sh_eff - 1'b1;
    col_inc  = {1'b0, col_q} + 1'b1;
    row_inc  = {1'b0, row_q} + 1'b1;
    // A counter left beyond a shrunken size counts as the last one.
    last_col = (col_inc >= dw_eff);
    last_row = (row_inc >= dh_eff);
  end

  // Raster position of the next pixel to arrive.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (cmd_i.capture) begin
      if (!in_data_i.mode) begin
        col_q <= '0;
        row_q <= '0;
      end else if (last_col) begin
        col_q <= '0;
        row_q <= last_row ? '0 : row_inc[CntW-1:0];
      end else begin
        col_q <= col_inc[CntW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      mode_q  <= in_data_i.mode;
      red_q   <= in_data_i.red;
      green_q <= in_data_i.green;
      blue_q  <= in_data_i.blue;
      dx_q    <= col_q;
      dy_q    <= row_q;
      last_q  <= in_data_i.mode & last_col & last_row;
    end
  end

  always_comb begin
    prod_luma = LumaOffW'(dy_q) * LumaOffW'(cfg_i.dst_pitch);
    prod_half = (LumaOffW-1)'(dy_q >> 1) * (LumaOffW-1)'(cfg_i.dst_pitch);
    prod_base = ChromaOffW'(cfg_i.dst_height) * ChromaOffW'(cfg_i.dst_pitch);
    // The counters already hold the next position here.
    prod_x    = DivW'(col_q) * DivW'(sw_eff);
    prod_y    = DivW'(row_q) * DivW'(sh_eff);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      luma_q      <= calc_luma(red_q, green_q, blue_q);
      cb_q        <= calc_cb(red_q, green_q, blue_q);
      cr_q        <= calc_cr(red_q, green_q, blue_q);
      prod_luma_q <= prod_luma;
      prod_half_q <= prod_half;
      prod_base_q <= prod_base;
      prod_x_q    <= prod_x;
      prod_y_q    <= prod_y;
    end
    if (cmd_i.sum) begin
      luma_off_q   <= prod_luma_q + LumaOffW'(dx_q);
      chroma_off_q <= prod_base_q + ChromaOffW'(prod_half_q) + ChromaOffW'(dx_q);
    end
  end

  b2nv12_div u_div_x (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (prod_x_q),
    .divisor_i  (dw_eff),
    .done_o     (x_done),
    .quotient_o (quo_x)
  );

  b2nv12_div u_div_y (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (prod_y_q),
    .divisor_i  (dh_eff),
    .done_o     (y_done),
    .quotient_o (quo_y)
  );

  always_comb begin
    sx_sat     = (quo_x > DivW'(sw_m1)) ? DivW'(sw_m1) : quo_x;
    sy_sat     = (quo_y > DivW'(sh_m1)) ? DivW'(sh_m1) : quo_y;
    prod_fetch = DivW'(rowsel_q) * DivW'(sw_eff);
  end

  // The source is stored bottom-up, so row sy sits at stored row sh-1-sy.
  always_ff @(posedge clk_i) begin
    if (cmd_i.row) begin
      sx_q     <= sx_sat[CntW-1:0];
      rowsel_q <= sh_m1[CntW-1:0] - sy_sat[CntW-1:0];
    end
    if (cmd_i.fetch) begin
      fetch_q <= FetchIdxW'(prod_fetch + DivW'(sx_q));
    end
  end

  always_comb begin
    chroma_pos                = mode_q & ~dx_q[0] & ~dy_q[0];
    out_d                     = '0;
    out_d.pixel_valid         = mode_q;
    out_d.frame_last          = last_q;
    out_d.next_fetch_offset   = {fetch_q, 2'b00};
    if (mode_q) begin
      out_d.luma        = luma_q;
      out_d.luma_offset = luma_off_q;
    end
    if (chroma_pos) begin
      out_d.chroma_valid  = 1'b1;
      out_d.chroma_blue   = cb_q;
      out_d.chroma_red    = cr_q;
      out_d.chroma_offset = chroma_off_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_q <= out_d;
    end
  end

  assign sts_o.div_done = x_done & y_done;
  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign out_data_o     = out_q;

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |-> (!out_valid_q || out_ready_i))
    else $error("result loaded over a beat that was not taken");

  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.capture |=> ({1'b0, col_q} < $past(dw_eff)))
    else $error("column counter left the destination width");

  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_start |-> (x_done && y_done))
    else $error("division started while a divider was busy");

  a_chroma_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.chroma_valid) |-> out_q.pixel_valid)
    else $error("chroma beat without a pixel");

  a_start_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.pixel_valid) |->
      (out_q.luma_offset == '0 && !out_q.frame_last && out_q.chroma_offset == '0))
    else $error("start beat carries pixel fields");

endmodule

// ----- rtl/core/bgra_to_nv12_scaled_converter_top.sv -----
// ----------------------------------------------------------------------------
// bgra_to_nv12_scaled_converter_top
// BGRA to NV12 converter with nearest-neighbor scaling, BT.601 limited range.
// ----------------------------------------------------------------------------
// Each input beat is either a start item (mode 0), which resets the raster
// position to the top-left destination pixel, or the BGRA source pixel for the
// current destination position (mode 1). Every input beat yields exactly one
// output beat carrying the source byte offset to fetch for the next position;
// a pixel beat also carries luma and its plane offset, and chroma at even
// column and row. The frame wraps on its own after the last pixel. One item
// is processed at a time, and two bit-serial dividers map the destination
// position to a source column and row, one quotient bit per cycle over 25
// bits. A finished result sits in the output register, and the next item is
// accepted while it waits. The configuration port is always ready and should
// only be written while idle.
module bgra_to_nv12_scaled_converter_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  b2nv12_pkg::in_t                  in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output b2nv12_pkg::out_t                 out_data_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [b2nv12_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [b2nv12_pkg::PitchW-1:0]    cfg_data_i
);
  import b2nv12_pkg::*;

  cfg_t cfg_q;
  cmd_t cmd;
  sts_t sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.src_width  <= DimW'(1920);
      cfg_q.src_height <= DimW'(1080);
      cfg_q.dst_width  <= DimW'(1920);
      cfg_q.dst_height <= DimW'(1080);
      cfg_q.dst_pitch  <= PitchW'(1920);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgSrcWidth:  cfg_q.src_width  <= cfg_data_i[DimW-1:0];
        CfgSrcHeight: cfg_q.src_height <= cfg_data_i[DimW-1:0];
        CfgDstWidth:  cfg_q.dst_width  <= cfg_data_i[DimW-1:0];
        CfgDstHeight: cfg_q.dst_height <= cfg_data_i[DimW-1:0];
        CfgDstPitch:  cfg_q.dst_pitch  <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  b2nv12_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  b2nv12_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
